// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/mcbd_pkg.sv =====
package mcbd_pkg;

  localparam int NUM_QUEUES_DEF = 32;
  localparam int DEPTH_DEF      = 8;
  localparam int ID_WIDTH_DEF   = 16;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_TAKE = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_REJECTED = 2'd1,
    ST_SERVED   = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic        func;
    logic [4:0]  queue_sel;
    logic        urgent;
    logic [15:0] entry_id;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] served_id;
    logic [3:0]  occupancy;
  } res_t;

endpackage

// ===== hw/rtl/multi_class_bounded_deque_core.sv =====
// Taking a request issues the metadata read. An add answers from S_META, a served
// take from S_SLOT after the slot memory read, a take on an empty class from S_META.
// A request is taken only while not busy; busy covers the pointer/count read-modify-write
// and, for a take, the slot memory read.
// Reset (rst, synchronous): all queues read as empty, no result pending.
// The result strobe (done) lasts one cycle and cannot be stalled.
module multi_class_bounded_deque_core import mcbd_pkg::*; #(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int DEPTH      = DEPTH_DEF,
  parameter int ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic done,
  output res_t result
);

  localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = CW + 1;
  localparam int SAW = $clog2(NUM_QUEUES * DEPTH);
  localparam int MW  = PW + CW;

  typedef struct packed {
    logic [PW-1:0] head;
    logic [CW-1:0] cnt;
  } meta_t;

  typedef enum logic [1:0] {S_IDLE, S_META, S_SLOT} state_t;

  state_t          state;
  cmd_t            req;
  logic [QW-1:0]   q_idx;
  logic            q_ok;
  logic [CW-1:0]   occ_hold;
  logic [NUM_QUEUES-1:0] meta_vld;

  logic            accept;
  logic [QW+4:0]   q_wide;
  logic [MW-1:0]   meta_rdata;
  meta_t           meta_cur;
  meta_t           meta_new;
  logic            meta_we;
  logic [QW-1:0]   meta_raddr;
  logic [PW-1:0]   head_dec;
  logic [PW-1:0]   head_inc;
  logic [SW-1:0]   tail_sum;
  logic [PW-1:0]   tail_pos;
  logic [PW-1:0]   slot_pos;
  logic [SAW-1:0]  slot_addr;
  logic            slot_we;
  logic            slot_re;
  logic [ID_WIDTH-1:0] slot_rdata;
  logic            is_full;
  logic            is_empty;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign q_wide = {{QW{1'b0}}, cmd.queue_sel};
  assign meta_raddr = q_wide[QW-1:0];

  // Queues never written since reset read as empty.
  assign meta_cur = (q_ok && meta_vld[q_idx]) ? meta_t'(meta_rdata) : '0;

  assign is_full  = (meta_cur.cnt >= CW'(DEPTH));
  assign is_empty = (meta_cur.cnt == '0);

  assign head_dec = (meta_cur.head == '0) ? PW'(DEPTH - 1) : meta_cur.head - 1'b1;
  assign head_inc = (meta_cur.head == PW'(DEPTH - 1)) ? '0 : meta_cur.head + 1'b1;
  assign tail_sum = SW'(meta_cur.head) + SW'(meta_cur.cnt);
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? PW'(tail_sum - SW'(DEPTH)) : PW'(tail_sum);

  always_comb begin
    meta_we  = 1'b0;
    slot_we  = 1'b0;
    slot_re  = 1'b0;
    meta_new = meta_cur;
    slot_pos = meta_cur.head;
    if (state == S_META && q_ok) begin
      if (req.func == FUNC_TAKE) begin
        if (!is_empty) begin
          meta_we       = 1'b1;
          slot_re       = 1'b1;
          meta_new.head = head_inc;
          meta_new.cnt  = meta_cur.cnt - 1'b1;
        end
      end else if (!is_full) begin
        meta_we       = 1'b1;
        slot_we       = 1'b1;
        meta_new.head = req.urgent ? head_dec : meta_cur.head;
        meta_new.cnt  = meta_cur.cnt + 1'b1;
        slot_pos      = req.urgent ? head_dec : tail_pos;
      end
    end
  end

  assign slot_addr = SAW'(q_idx) * SAW'(DEPTH) + SAW'(slot_pos);

  mcbd_ram #(.WIDTH(MW), .DEPTH(NUM_QUEUES)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (q_idx),
    .wdata (MW'(meta_new)),
    .re    (accept),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  mcbd_ram #(.WIDTH(ID_WIDTH), .DEPTH(NUM_QUEUES * DEPTH)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (ID_WIDTH'(req.entry_id)),
    .re    (slot_re),
    .raddr (slot_addr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      meta_vld <= '0;
    end else begin
      done <= 1'b0;
      if (meta_we) begin
        meta_vld[q_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req   <= cmd;
            q_idx <= q_wide[QW-1:0];
            q_ok  <= (q_wide < (QW+5)'(NUM_QUEUES));
            state <= S_META;
          end
        end
        S_META: begin
          result.served_id <= '0;
          if (!q_ok) begin
            result.status    <= (req.func == FUNC_TAKE) ? ST_EMPTY : ST_REJECTED;
            result.occupancy <= '0;
            done             <= 1'b1;
            state            <= S_IDLE;
          end else if (req.func == FUNC_TAKE) begin
            if (is_empty) begin
              result.status    <= ST_EMPTY;
              result.occupancy <= '0;
              done             <= 1'b1;
              state            <= S_IDLE;
            end else begin
              // hold the new count until the slot data comes back
              occ_hold <= meta_new.cnt;
              state    <= S_SLOT;
            end
          end else begin
            result.status    <= is_full ? ST_REJECTED : ST_ADDED;
            result.occupancy <= 4'(meta_new.cnt);
            done             <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_SLOT: begin
          result.status    <= ST_SERVED;
          result.served_id <= 16'(slot_rdata);
          result.occupancy <= 4'(occ_hold);
          done             <= 1'b1;
          state            <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/mcbd_ram.sv =====
module mcbd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/mcbd_checker.sv =====
`include "assert_macros.svh"

module mcbd_checker import mcbd_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input cmd_t cmd,
  input logic busy,
  input logic done,
  input res_t result
);

  `ASSERT_NOW(a_done_idle, done, !busy)
  `ASSERT_NEXT(a_req_busy, start && !busy, busy && !done)
  `ASSERT_NEXT(a_add_lat, start && !busy && cmd.func == FUNC_ADD, ##1 done)
  `ASSERT_NEXT(a_take_lat, start && !busy && cmd.func == FUNC_TAKE, ##1 (done || busy))
  `ASSERT_NOW(a_empty_zero, done && result.status == ST_EMPTY,
              result.occupancy == 4'd0 && result.served_id == 16'd0)

endmodule

bind multi_class_bounded_deque_core mcbd_checker u_mcbd_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .cmd    (cmd),
  .busy   (busy),
  .done   (done),
  .result (result)
);

// ===== bench/deque_monitor.sv =====
`timescale 1ns / 1ps

module deque_monitor import mcbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  cmd_t cmd,
  input  logic done,
  input  res_t result,
  output int   failures,
  output int   pending,
  output int   checked,
  output int   full_hits,
  output int   empty_hits
);

  int   ring_head [NUM_QUEUES_DEF];
  int   ring_fill [NUM_QUEUES_DEF];
  logic [15:0] id_slots [NUM_QUEUES_DEF * DEPTH_DEF];
  res_t awaited_results [$];

  // Apply one request to the shadow queues and return the answer it earns.
  function automatic res_t apply_request(cmd_t c);
    res_t r;
    int   q;
    int   hd;
    int   cnt;
    r.status    = ST_ADDED;
    r.served_id = '0;
    r.occupancy = '0;
    q   = c.queue_sel;
    if (q >= NUM_QUEUES_DEF) begin
      r.status = (c.func == FUNC_TAKE) ? ST_EMPTY : ST_REJECTED;
      return r;
    end
    hd  = ring_head[q];
    cnt = ring_fill[q];
    if (c.func == FUNC_ADD) begin
      if (cnt >= DEPTH_DEF) begin
        r.status    = ST_REJECTED;
        r.occupancy = 4'(cnt);
      end else begin
        // urgent entries slide in ahead of the head, regular ones behind the tail
        if (c.urgent) begin
          hd = (hd + DEPTH_DEF - 1) % DEPTH_DEF;
          id_slots[q * DEPTH_DEF + hd] = c.entry_id;
        end else begin
          id_slots[q * DEPTH_DEF + (hd + cnt) % DEPTH_DEF] = c.entry_id;
        end
        cnt++;
        r.status    = ST_ADDED;
        r.occupancy = 4'(cnt);
      end
    end else if (cnt == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status    = ST_SERVED;
      r.served_id = id_slots[q * DEPTH_DEF + hd];
      hd = (hd + 1) % DEPTH_DEF;
      cnt--;
      r.occupancy = 4'(cnt);
    end
    ring_head[q] = hd;
    ring_fill[q] = cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    int   errs;
    int   n_full;
    int   n_empty;
    int   n_checked;
    errs      = 0;
    n_full    = 0;
    n_empty   = 0;
    n_checked = 0;
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES_DEF; i++) begin
        ring_head[i] = 0;
        ring_fill[i] = 0;
      end
      awaited_results.delete();
    end else begin
      // compare first: a result on this edge always belongs to an older request
      if (done) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d id=%h occ=%0d", $time,
                   result.status, result.served_id, result.occupancy);
          errs++;
        end else begin
          want = awaited_results.pop_front();
          n_checked = 1;
          if (result.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, result.status);
            errs++;
          end
          if (result.served_id !== want.served_id) begin
            $display("%0t: served_id expected %h actual %h", $time,
                     want.served_id, result.served_id);
            errs++;
          end
          if (result.occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d", $time,
                     want.occupancy, result.occupancy);
            errs++;
          end
          if (want.status == ST_REJECTED) n_full = 1;
          if (want.status == ST_EMPTY) n_empty = 1;
        end
      end
      if (start && !busy)
        awaited_results.push_back(apply_request(cmd));
    end
    failures   <= failures + errs;
    checked    <= checked + n_checked;
    full_hits  <= full_hits + n_full;
    empty_hits <= empty_hits + n_empty;
    pending    <= awaited_results.size();
  end

endmodule

// ===== bench/multi_class_bounded_deque_core_tb.sv =====
`timescale 1ns / 1ps

module multi_class_bounded_deque_core_tb;
  import mcbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 1600;
  localparam int SEGMENT     = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  res_t result;

  int failures;
  int pending;
  int checked;
  int full_hits;
  int empty_hits;
  int cycles = 0;
  int sent = 0;
  int adds = 0;
  int takes = 0;

  multi_class_bounded_deque_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  deque_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done),
    .result     (result),
    .failures   (failures),
    .pending    (pending),
    .checked    (checked),
    .full_hits  (full_hits),
    .empty_hits (empty_hits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic fn, logic [4:0] q, logic urg, logic [15:0] id);
    cmd_t c;
    c.func      = fn;
    c.queue_sel = q;
    c.urgent    = urg;
    c.entry_id  = id;
    return c;
  endfunction

  // Hold the request until it is taken, then idle for the given gap.
  // With no gap, start stays high so the next request follows at once.
  task automatic issue(input cmd_t c, input int gap);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (c.func == FUNC_ADD) adds++;
    else takes++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    logic [15:0] ids [9];
    int          hot;
    int          add_pct;
    bit          no_idle;
    int          gap;
    cmd_t        c;

    ids = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001,
            16'h8000, 16'h7FFE, 16'h1234, 16'hBEEF};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill class 0 with both kinds of add, overflow it, then drain past empty
    for (int i = 0; i < 9; i++)
      issue(make_cmd(FUNC_ADD, 5'd0, i[0], ids[i]), $urandom_range(0, 3));
    for (int i = 0; i < 9; i++)
      issue(make_cmd(FUNC_TAKE, 5'd0, 1'b0, 16'h0000), $urandom_range(0, 3));
    // top class index
    issue(make_cmd(FUNC_ADD, 5'd31, 1'b1, 16'hFFFF), 0);
    issue(make_cmd(FUNC_ADD, 5'd31, 1'b0, 16'h0000), 0);
    issue(make_cmd(FUNC_TAKE, 5'd31, 1'b1, 16'hFFFF), 0);
    issue(make_cmd(FUNC_TAKE, 5'd31, 1'b0, 16'h0000), 0);
    issue(make_cmd(FUNC_TAKE, 5'd31, 1'b0, 16'h0000), 0);
    wait_drained();

    hot     = 0;
    add_pct = 50;
    no_idle = 1'b0;
    for (int n = 0; n < RANDOM_REQS; n++) begin
      // per segment: pick a busy class and an add/take mix so queues fill and drain
      if (n % SEGMENT == 0) begin
        hot = $urandom_range(0, 31);
        case ($urandom_range(0, 2))
          0: add_pct = 85;
          1: add_pct = 50;
          default: add_pct = 15;
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if (n == RANDOM_REQS / 2) wait_drained();
      c.func      = ($urandom_range(0, 99) < add_pct) ? FUNC_ADD : FUNC_TAKE;
      c.queue_sel = ($urandom_range(0, 99) < 70) ? 5'(hot) : 5'($urandom_range(0, 31));
      c.urgent    = 1'($urandom_range(0, 1));
      c.entry_id  = 16'($urandom);
      gap = no_idle ? 0 : $urandom_range(0, 7);
      issue(c, gap);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("run: %0d requests (%0d adds, %0d takes), %0d results checked", sent, adds,
             takes, checked);
    $display("run: %0d adds hit a full class, %0d takes found a class empty", full_hits,
             empty_hits);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
